/* hdl/cpr_pkg.sv */
`timescale 1ns / 1ps

package cpr_pkg;

  // Frame table geometry
  localparam int MAX_FRAMES = 64;
  localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // Fixed field widths
  localparam int ADDR_W       = 32;
  localparam int PAGE_SHIFT   = 12;
  localparam int PAGE_W       = ADDR_W - PAGE_SHIFT;
  localparam int CFG_W        = 7;
  localparam int FRAME_SLOT_W = 6;
  localparam int TOTAL_W      = 32;

  // Frames managed after reset
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [1:0] {
    OUT_HIT         = 2'd0,
    OUT_FILL        = 2'd1,
    OUT_EVICT_CLEAN = 2'd2,
    OUT_EVICT_DIRTY = 2'd3
  } outcome_t;

  // Update request from the sequencer to the frame store
  typedef struct packed {
    logic              load;     // new page into slot, ref set, dirty = wr
    logic              touch;    // hit: ref set, dirty |= wr
    logic              clr_ref;  // sweep: clear ref of slot
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page;
    logic              wr;
  } store_cmd_t;

  // Finished request handed to the output stage
  typedef struct packed {
    logic              commit;
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] victim;
  } seq_result_t;

  // Clamp the configured frame count to 1..MAX_FRAMES
  function automatic logic [CNT_W-1:0] clamp_frames(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) w = 32'd1;
    if (w > 32'(MAX_FRAMES)) w = 32'(MAX_FRAMES);
    return CNT_W'(w);
  endfunction

endpackage

/* hdl/clock_page_replacement.sv */
`timescale 1ns / 1ps

// Clock (second-chance) page replacement unit.
// Input channel: in_valid / in_stall carry one access request (access_address,
// is_write). Output channel: out_valid / out_stall carry one result per request
// (outcome, frame_slot, victim_page and the three running totals).
// Config: cfg_wen writes cfg_wdata into frames_in_use (0 acts as 1, values
// above 64 act as 64); write it only while no request is in flight.
// Timing: one request at a time; in_stall is high from acceptance until the
// result is loaded into the output register, and the next one can be taken in
// the cycle after. Frames are searched one per cycle through the page memory
// read port.
// Reset: all frames empty, referenced/dirty bits clear, hand and totals zero,
// frames_in_use = 64. The frame page memory is not cleared; only filled
// frames are ever compared.
// Stall: a result waits in the output register; the next request is taken
// and searched meanwhile, but holds before its own result until the output
// register frees.
module clock_page_replacement (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cpr_pkg::ADDR_W-1:0]        access_address,
  input  logic                              is_write,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        outcome,
  output logic [cpr_pkg::FRAME_SLOT_W-1:0]  frame_slot,
  output logic [cpr_pkg::PAGE_W-1:0]        victim_page,
  output logic [cpr_pkg::TOTAL_W-1:0]       access_total,
  output logic [cpr_pkg::TOTAL_W-1:0]       fault_total,
  output logic [cpr_pkg::TOTAL_W-1:0]       writeback_total,
  input  logic                              cfg_wen,
  input  logic [cpr_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [cpr_pkg::CFG_W-1:0]  frames_in_use;
  logic                       busy;
  logic                       out_free;
  logic                       in_take;
  logic [cpr_pkg::SLOT_W-1:0] rd_addr;
  logic [cpr_pkg::PAGE_W-1:0] rd_page;
  logic                       ref_bit;
  logic                       dirty_bit;
  cpr_pkg::store_cmd_t        cmd;
  cpr_pkg::seq_result_t       result;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  assign out_free = !out_valid || !out_stall;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= cpr_pkg::CFG_RESET;
    end else if (cfg_wen) begin
      frames_in_use <= cfg_wdata;
    end
  end

  cpr_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .rd_page   (rd_page),
    .cmd       (cmd),
    .ref_bit   (ref_bit),
    .dirty_bit (dirty_bit)
  );

  cpr_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (in_take),
    .start_page (access_address[cpr_pkg::ADDR_W-1:cpr_pkg::PAGE_SHIFT]),
    .start_wr   (is_write),
    .frames_cfg (frames_in_use),
    .out_free   (out_free),
    .busy       (busy),
    .rd_addr    (rd_addr),
    .rd_page    (rd_page),
    .cmd        (cmd),
    .ref_bit    (ref_bit),
    .dirty_bit  (dirty_bit),
    .result     (result)
  );

  // Output register and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      access_total    <= '0;
      fault_total     <= '0;
      writeback_total <= '0;
    end else if (result.commit) begin
      out_valid    <= 1'b1;
      access_total <= access_total + 1'b1;
      if (result.outcome != cpr_pkg::OUT_HIT) begin
        fault_total <= fault_total + 1'b1;
      end
      if (result.outcome == cpr_pkg::OUT_EVICT_DIRTY) begin
        writeback_total <= writeback_total + 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.commit) begin
      outcome     <= result.outcome;
      frame_slot  <= cpr_pkg::FRAME_SLOT_W'(result.slot);
      victim_page <= result.victim;
    end
  end

  // Checks
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    result.commit |-> out_free)
    else $error("result committed while output register held");

  a_access_count: assert property (@(posedge clk) disable iff (rst)
    result.commit |=> access_total == $past(access_total) + 1'b1)
    else $error("access total did not advance on commit");

  a_dirty_count: assert property (@(posedge clk) disable iff (rst)
    (result.commit && result.outcome == cpr_pkg::OUT_EVICT_DIRTY)
      |=> writeback_total == $past(writeback_total) + 1'b1)
    else $error("writeback total did not advance on dirty eviction");

  a_hit_no_victim: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == cpr_pkg::OUT_HIT) |-> victim_page == '0)
    else $error("hit reported a victim page");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load || result.commit)
    else $error("frame loaded outside commit");

endmodule

/* hdl/cpr_frame_store.sv */
`timescale 1ns / 1ps

module cpr_frame_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [cpr_pkg::SLOT_W-1:0] rd_addr,
  output logic [cpr_pkg::PAGE_W-1:0] rd_page,
  input  cpr_pkg::store_cmd_t        cmd,
  output logic                       ref_bit,
  output logic                       dirty_bit
);

  logic [cpr_pkg::PAGE_W-1:0]     page_mem [cpr_pkg::MAX_FRAMES];
  logic [cpr_pkg::MAX_FRAMES-1:0] ref_vec;
  logic [cpr_pkg::MAX_FRAMES-1:0] dirty_vec;

  // Page memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_mem[cmd.slot] <= cmd.page;
    end
    rd_page <= page_mem[rd_addr];
  end

  // Referenced and dirty bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_vec   <= '0;
      dirty_vec <= '0;
    end else begin
      if (cmd.load) begin
        ref_vec[cmd.slot]   <= 1'b1;
        dirty_vec[cmd.slot] <= cmd.wr;
      end else if (cmd.touch) begin
        ref_vec[cmd.slot] <= 1'b1;
        if (cmd.wr) begin
          dirty_vec[cmd.slot] <= 1'b1;
        end
      end else if (cmd.clr_ref) begin
        ref_vec[cmd.slot] <= 1'b0;
      end
    end
  end

  // Bit reads follow the page read address (sweep position or victim)
  assign ref_bit   = ref_vec[rd_addr];
  assign dirty_bit = dirty_vec[rd_addr];

endmodule

/* hdl/cpr_seq.sv */
`timescale 1ns / 1ps

module cpr_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cpr_pkg::PAGE_W-1:0] start_page,
  input  logic                       start_wr,
  input  logic [cpr_pkg::CFG_W-1:0]  frames_cfg,
  input  logic                       out_free,
  output logic                       busy,
  output logic [cpr_pkg::SLOT_W-1:0] rd_addr,
  input  logic [cpr_pkg::PAGE_W-1:0] rd_page,
  output cpr_pkg::store_cmd_t        cmd,
  input  logic                       ref_bit,
  input  logic                       dirty_bit,
  output cpr_pkg::seq_result_t       result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MISS,
    ST_SWEEP,
    ST_EVICT,
    ST_DONE
  } state_t;

  state_t                     state;
  logic [cpr_pkg::PAGE_W-1:0] page;
  logic                       wr;
  logic [cpr_pkg::CNT_W-1:0]  n;
  logic [cpr_pkg::CNT_W-1:0]  limit;
  logic [cpr_pkg::CNT_W-1:0]  idx;
  logic [cpr_pkg::CNT_W-1:0]  filled;
  logic [cpr_pkg::SLOT_W-1:0] hand;
  logic [cpr_pkg::SLOT_W-1:0] slot;
  cpr_pkg::outcome_t          outcome;
  logic [cpr_pkg::PAGE_W-1:0] victim;

  logic [cpr_pkg::CNT_W-1:0]  n_in;
  logic [cpr_pkg::CNT_W-1:0]  limit_in;
  logic [cpr_pkg::CNT_W-1:0]  idx_inc;
  logic [cpr_pkg::CNT_W-1:0]  hand_inc;
  logic [cpr_pkg::SLOT_W-1:0] hand_next;
  logic                       commit;

  // Request setup
  assign n_in     = cpr_pkg::clamp_frames(frames_cfg);
  assign limit_in = (filled < n_in) ? filled : n_in;
  assign idx_inc  = idx + 1'b1;
  assign hand_inc = cpr_pkg::CNT_W'(hand) + 1'b1;
  assign hand_next = (hand_inc >= n) ? '0 : cpr_pkg::SLOT_W'(hand_inc);
  assign commit   = (state == ST_DONE) && out_free;
  assign busy     = (state != ST_IDLE);

  // Read address: next scan entry, sweep position or victim
  always_comb begin
    unique case (state)
      ST_IDLE:  rd_addr = '0;
      ST_SCAN:  rd_addr = cpr_pkg::SLOT_W'(idx_inc);
      ST_SWEEP: rd_addr = hand;
      default:  rd_addr = slot;
    endcase
  end

  // Frame store updates
  always_comb begin
    cmd         = '0;
    cmd.slot    = slot;
    cmd.page    = page;
    cmd.wr      = wr;
    if (state == ST_SWEEP) begin
      cmd.slot    = hand;
      cmd.clr_ref = ref_bit;
    end
    if (commit) begin
      cmd.load  = (outcome != cpr_pkg::OUT_HIT);
      cmd.touch = (outcome == cpr_pkg::OUT_HIT);
    end
  end

  assign result.commit  = commit;
  assign result.outcome = outcome;
  assign result.slot    = slot;
  assign result.victim  = victim;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      filled <= '0;
      hand   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            page    <= start_page;
            wr      <= start_wr;
            n       <= n_in;
            limit   <= limit_in;
            idx     <= '0;
            victim  <= '0;
            outcome <= cpr_pkg::OUT_HIT;
            state   <= (limit_in == '0) ? ST_MISS : ST_SCAN;
          end
        end
        // one compare per cycle, lowest index first
        ST_SCAN: begin
          if (rd_page == page) begin
            slot    <= cpr_pkg::SLOT_W'(idx);
            outcome <= cpr_pkg::OUT_HIT;
            state   <= ST_DONE;
          end else if (idx_inc >= limit) begin
            state <= ST_MISS;
          end else begin
            idx <= idx_inc;
          end
        end
        ST_MISS: begin
          if (filled < n) begin
            slot    <= cpr_pkg::SLOT_W'(filled);
            outcome <= cpr_pkg::OUT_FILL;
            state   <= ST_DONE;
          end else begin
            if (cpr_pkg::CNT_W'(hand) >= n) begin
              hand <= '0;
            end
            state <= ST_SWEEP;
          end
        end
        // second-chance sweep, one frame per cycle
        ST_SWEEP: begin
          hand <= hand_next;
          if (!ref_bit) begin
            slot  <= hand;
            state <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          victim  <= rd_page;
          outcome <= dirty_bit ? cpr_pkg::OUT_EVICT_DIRTY : cpr_pkg::OUT_EVICT_CLEAN;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            if (outcome == cpr_pkg::OUT_FILL) begin
              filled <= filled + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* bench/frame_table_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the page replacement unit, keeps its own copy of
// the frame table, and checks every result against the predicted one.
module frame_table_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [cpr_pkg::ADDR_W-1:0]        access_address,
  input  logic                              is_write,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [1:0]                        outcome,
  input  logic [cpr_pkg::FRAME_SLOT_W-1:0]  frame_slot,
  input  logic [cpr_pkg::PAGE_W-1:0]        victim_page,
  input  logic [cpr_pkg::TOTAL_W-1:0]       access_total,
  input  logic [cpr_pkg::TOTAL_W-1:0]       fault_total,
  input  logic [cpr_pkg::TOTAL_W-1:0]       writeback_total,
  input  logic                              cfg_wen,
  input  logic [cpr_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                fail_count,
  output int                                pending,
  output int                                hit_count,
  output int                                fill_count,
  output int                                clean_count,
  output int                                dirty_count
);

  import cpr_pkg::*;

  typedef struct {
    outcome_t                  outcome;
    logic [FRAME_SLOT_W-1:0]   slot;
    logic [PAGE_W-1:0]         victim;
    logic [TOTAL_W-1:0]        accesses;
    logic [TOTAL_W-1:0]        faults;
    logic [TOTAL_W-1:0]        writebacks;
  } access_result_t;

  // Shadow frame table and counters
  logic [PAGE_W-1:0]  page_tab [MAX_FRAMES];
  bit                 dirty_tab [MAX_FRAMES];
  bit                 ref_tab [MAX_FRAMES];
  int                 filled;
  int                 hand;
  logic [TOTAL_W-1:0] n_access;
  logic [TOTAL_W-1:0] n_fault;
  logic [TOTAL_W-1:0] n_writeback;
  logic [CFG_W-1:0]   frames_cfg;

  access_result_t     expected_results [$];
  access_result_t     next_result;
  int                 result_index;
  int                 k;

  // Next result for one access; updates the shadow table
  task automatic predict_access(input logic [ADDR_W-1:0] addr, input logic wr,
                                output access_result_t r);
    logic [PAGE_W-1:0] page;
    int n;
    int lim;
    int i;
    int slot;
    int h;
    bit hit;
    bit found;
    page = addr[ADDR_W-1:PAGE_SHIFT];
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    lim = (filled < n) ? filled : n;
    r.outcome = OUT_HIT;
    r.victim = '0;
    slot = 0;
    hit = 1'b0;

    // lowest matching filled frame wins
    for (i = 0; i < lim && !hit; i++) begin
      if (page_tab[i] == page) begin
        hit = 1'b1;
        slot = i;
      end
    end

    if (hit) begin
      ref_tab[slot] = 1'b1;
      if (wr) dirty_tab[slot] = 1'b1;
    end else if (filled < n) begin
      slot = filled;
      filled++;
      n_fault++;
      r.outcome = OUT_FILL;
    end else begin
      // second-chance sweep; hand restarts if the frame count shrank under it
      if (hand >= n) hand = 0;
      found = 1'b0;
      while (!found) begin
        h = hand;
        hand = (h + 1 >= n) ? 0 : h + 1;
        if (!ref_tab[h]) begin
          slot = h;
          found = 1'b1;
        end else begin
          ref_tab[h] = 1'b0;
        end
      end
      r.victim = page_tab[slot];
      if (dirty_tab[slot]) begin
        n_writeback++;
        r.outcome = OUT_EVICT_DIRTY;
      end else begin
        r.outcome = OUT_EVICT_CLEAN;
      end
      n_fault++;
    end

    // new page: referenced, dirty follows the access
    if (!hit) begin
      page_tab[slot] = page;
      dirty_tab[slot] = wr;
      ref_tab[slot] = 1'b1;
    end
    n_access++;
    r.slot = FRAME_SLOT_W'(slot);
    r.accesses = n_access;
    r.faults = n_fault;
    r.writebacks = n_writeback;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: result %0d %s mismatch: expected %0h, actual %0h",
               $time, result_index, name, want, got);
      fail_count++;
    end
  endtask

  // Match one accepted result against the oldest prediction
  task automatic check_result();
    access_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t ns: result %0d arrived with no request outstanding",
               $time, result_index);
      fail_count++;
    end else begin
      want = expected_results.pop_front();
      compare_field("outcome", 32'(want.outcome), 32'(outcome));
      compare_field("frame_slot", 32'(want.slot), 32'(frame_slot));
      compare_field("victim_page", 32'(want.victim), 32'(victim_page));
      compare_field("access_total", want.accesses, access_total);
      compare_field("fault_total", want.faults, fault_total);
      compare_field("writeback_total", want.writebacks, writeback_total);
      case (want.outcome)
        OUT_HIT:         hit_count++;
        OUT_FILL:        fill_count++;
        OUT_EVICT_CLEAN: clean_count++;
        default:         dirty_count++;
      endcase
    end
    result_index++;
  endtask

  // Sample everything at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (k = 0; k < MAX_FRAMES; k++) begin
        dirty_tab[k] = 1'b0;
        ref_tab[k] = 1'b0;
      end
      filled = 0;
      hand = 0;
      n_access = '0;
      n_fault = '0;
      n_writeback = '0;
      frames_cfg = CFG_RESET;
      expected_results.delete();
      result_index = 0;
      fail_count = 0;
      hit_count = 0;
      fill_count = 0;
      clean_count = 0;
      dirty_count = 0;
    end else begin
      if (cfg_wen) frames_cfg = cfg_wdata;
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        predict_access(access_address, is_write, next_result);
        expected_results.push_back(next_result);
      end
    end
    pending = expected_results.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  import cpr_pkg::*;

  localparam int GAP_MAX      = 18;
  localparam int CHOKE_CYCLES = 400;
  localparam int TAIL_CYCLES  = 200;
  localparam int TOTAL_ITEMS  = 620;
  localparam int POOL_DEPTH   = 128;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ADDR_W-1:0]        access_address = '0;
  logic                     is_write = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               outcome;
  logic [FRAME_SLOT_W-1:0]  frame_slot;
  logic [PAGE_W-1:0]        victim_page;
  logic [TOTAL_W-1:0]       access_total;
  logic [TOTAL_W-1:0]       fault_total;
  logic [TOTAL_W-1:0]       writeback_total;
  logic                     cfg_wen = 1'b0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  int fail_count;
  int pending;
  int hit_count;
  int fill_count;
  int clean_count;
  int dirty_count;

  bit calm = 1'b0;
  bit choke_req = 1'b0;
  int issued = 0;
  int settings = 0;

  logic [PAGE_W-1:0] page_pool [POOL_DEPTH];
  int pool_size;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  clock_page_replacement DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .access_address  (access_address),
    .is_write        (is_write),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .outcome         (outcome),
    .frame_slot      (frame_slot),
    .victim_page     (victim_page),
    .access_total    (access_total),
    .fault_total     (fault_total),
    .writeback_total (writeback_total),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata)
  );

  frame_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .access_address  (access_address),
    .is_write        (is_write),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .outcome         (outcome),
    .frame_slot      (frame_slot),
    .victim_page     (victim_page),
    .access_total    (access_total),
    .fault_total     (fault_total),
    .writeback_total (writeback_total),
    .cfg_wen         (cfg_wen),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .hit_count       (hit_count),
    .fill_count      (fill_count),
    .clean_count     (clean_count),
    .dirty_count     (dirty_count)
  );

  // Offer one request after a random gap; returns at the negedge after acceptance
  task automatic offer_access(input logic [ADDR_W-1:0] addr, input logic wr);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    access_address <= addr;
    is_write <= wr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    issued++;
  endtask

  // Frame count is only changed once every request has come back
  task automatic set_frames(input int v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_wen <= 1'b0;
    settings++;
  endtask

  // Receiver: random hold-off after each result, plus one long choke on request
  initial begin
    int hold;
    bit took;
    hold = 0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall && !rst;
      @(negedge clk);
      if (choke_req) begin
        hold = CHOKE_CYCLES;
        choke_req = 1'b0;
      end else if (took) begin
        hold = calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int frame_plan [15];
    int phase;
    int v;
    int eff;
    int len;
    logic [ADDR_W-1:0] addr;
    frame_plan = '{64, 1, 2, 3, 5, 8, 16, 31, 33, 63, 64, 0, 100, 7, 127};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: fills, hits, dirty and clean evictions at four frames
    set_frames(4);
    offer_access(32'h0000_0000, 1'b0);
    offer_access(32'hFFFF_FFFF, 1'b1);
    offer_access(32'h0000_0FFF, 1'b1);
    offer_access(32'hFFFF_F000, 1'b0);
    offer_access(32'h1234_5678, 1'b0);
    offer_access(32'h9ABC_DEF0, 1'b1);
    offer_access(32'h5555_5000, 1'b0);
    offer_access(32'hAAAA_A000, 1'b1);
    offer_access(32'h1234_5000, 1'b0);
    offer_access(32'h7777_7000, 1'b0);
    offer_access(32'h3333_3000, 1'b0);
    // shrink under the hand: a page held above the limit misses
    set_frames(2);
    offer_access(32'h7777_7ABC, 1'b0);
    // grow back: the same page now sits in two frames, lowest one wins
    set_frames(4);
    offer_access(32'h7777_7000, 1'b1);
    // zero acts as a single frame
    set_frames(0);
    offer_access(32'h8000_0000, 1'b1);
    offer_access(32'h8000_0123, 1'b0);
    offer_access(32'h0000_1000, 1'b0);
    // values above the table size act as the full table
    set_frames(127);
    offer_access(32'hDEAD_BEEF, 1'b1);
    offer_access(32'h0000_1FFF, 1'b0);
    set_frames(65);
    offer_access(32'hCAFE_0000, 1'b0);
    offer_access(32'hFFFF_FFFF, 1'b0);

    // Random phases: a working set a bit larger than the frame count
    for (int i = 0; i < POOL_DEPTH; i++) page_pool[i] = PAGE_W'($urandom);
    phase = 0;
    while (issued < TOTAL_ITEMS) begin
      v = (phase < 15) ? frame_plan[phase] : $urandom_range(0, 127);
      set_frames(v);
      eff = (v < 1) ? 1 : (v > MAX_FRAMES) ? MAX_FRAMES : v;
      pool_size = eff + $urandom_range(1, eff / 2 + 2);
      if (pool_size > POOL_DEPTH) pool_size = POOL_DEPTH;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if ($urandom_range(0, 1) != 0) page_pool[i] = PAGE_W'($urandom);
      end
      calm = (phase == 2) || ($urandom_range(0, 3) == 0);
      // one phase with back-to-back requests against a blocked output
      if (phase == 2) choke_req = 1'b1;
      len = 40 + $urandom_range(0, 20);
      repeat (len) begin
        if ($urandom_range(0, 99) < 85)
          addr = {page_pool[$urandom_range(0, pool_size - 1)], 12'($urandom)};
        else
          addr = $urandom;
        offer_access(addr, 1'($urandom_range(0, 1)));
      end
      phase++;
    end

    // Drain, then give any stray result time to show up
    in_valid <= 1'b0;
    calm = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d accesses over %0d frame-count settings (0, 1..64 and above 64).",
             issued, settings);
    $display("Results: %0d hits, %0d fills, %0d clean and %0d dirty evictions.",
             hit_count, fill_count, clean_count, dirty_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
